@@ sv/ffha_pkg.sv @@
package ffha_pkg;
  localparam int MaxBlocksDef = 64;
  localparam int HeaderBytesDef = 16;
  localparam int HeapBytesDef = 4194304;
  localparam logic [31:0] HeapBaseRst = 32'h0010_0000;
  localparam logic [24:0] TotalBytesRst = 25'h100_0000;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ZERO = 3'd1;
  localparam logic [2:0] ST_NOFIT = 3'd2;
  localparam logic [2:0] ST_NULL = 3'd3;
  localparam logic [2:0] ST_DOUBLE = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_TOTAL = 1'b1;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] granted_address;
    logic [24:0] used_bytes;
    logic [24:0] free_bytes;
    logic [6:0] block_count;
  } result_t;
endpackage

@@ sv/first_fit_heap_allocator_top.sv @@
// channel | dir | payload
// in_     | in  | tdata {release_address, request_bytes}, tuser opcode
// out_    | out | tdata {block_count, free_bytes, used_bytes, granted_address, status}
// cfg_    | in  | index 0 heap_base, 1 total_bytes
// an item walks the table entries, moves entries one at a time for a split
// or merge and compares neighbor pairs in the merge pass; the registered-read
// table memory sets the pace of each of these steps.
// in_tready is low while an item is at work or a register write is offered;
// a waiting result holds the finish of the next item and any register write.
// reset rst_n is synchronous; no clearing pass is needed.
module first_fit_heap_allocator_top #(
  parameter int MAX_BLOCKS = ffha_pkg::MaxBlocksDef,
  parameter int HEADER_BYTES = ffha_pkg::HeaderBytesDef,
  parameter int HEAP_BYTES = ffha_pkg::HeapBytesDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [63:0] in_tdata,   // request_bytes, release_address
  input  logic in_tuser,          // opcode
  output logic out_tvalid,
  input  logic out_tready,
  output logic [95:0] out_tdata,  // status, granted_address, used_bytes, free_bytes, block_count
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [31:0] cfg_data
);
  import ffha_pkg::*;
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = AW + 1;
  localparam int SW = $clog2(HEAP_BYTES);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_SCAN = 9'b000000010, S_SCHK = 9'b000000100,
    S_SHUP = 9'b000001000, S_SPLT = 9'b000010000, S_MRGR = 9'b000100000,
    S_MRGC = 9'b001000000, S_SHDN = 9'b010000000, S_DONE = 9'b100000000
  } state_t;

  state_t st_r;
  logic [31:0] heap_base_r;
  logic [24:0] used_r, free_r;
  logic [CW-1:0] cnt_r;
  logic op_r;
  logic [32:0] need_r;
  logic [31:0] rnd_r, addr_r, off_r;
  logic [CW-1:0] i_r, j_r;
  logic [SW-1:0] cur_size_r;
  logic cur_free_r;
  logic out_valid_r;
  logic [2:0] wk_status_r;
  logic [31:0] wk_addr_r;
  result_t res_r;

  logic wen_r;
  logic [AW-1:0] waddr_r;
  logic [SW-1:0] wsize_r;
  logic wfree_r;
  logic [1:0] ph_r;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [SW-1:0] rd_size, wr_size;
  logic rd_free, wr_free, wr_en;

  ffha_table #(.MAX_BLOCKS(MAX_BLOCKS), .HEAP_BYTES(HEAP_BYTES),
               .HEADER_BYTES(HEADER_BYTES)) u_table (
    .clk, .rst_n, .rd_addr, .rd_size, .rd_free,
    .wr_en, .wr_addr, .wr_size, .wr_free);

  logic [32:0] rnd_w;
  assign rnd_w = ({1'b0, in_tdata[31:0]} + 33'd7) & ~33'd7;
  assign in_tready = (st_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (st_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(96 - $bits(result_t)){1'b0}}, res_r.block_count, res_r.free_bytes,
                      res_r.used_bytes, res_r.granted_address, res_r.status};

  logic [31:0] blk_bytes;
  assign blk_bytes = 32'(cur_size_r) + 32'(HEADER_BYTES);

  // memory read issued a cycle ahead, data in the following state
  always_comb begin
    unique case (st_r)
      S_SHUP: rd_addr = AW'(j_r - 1'b1);
      S_MRGC, S_SHDN: rd_addr = AW'(j_r);
      default: rd_addr = i_r[AW-1:0];
    endcase
  end

  // writes driven from registered sequencer outputs
  assign wr_en = wen_r;
  assign wr_addr = waddr_r;
  assign wr_size = wsize_r;
  assign wr_free = wfree_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      heap_base_r <= HeapBaseRst;
      used_r <= '0;
      free_r <= TotalBytesRst;
      cnt_r <= CW'(1);
      out_valid_r <= 1'b0;
      wen_r <= 1'b0;
      ph_r <= '0;
    end else begin
      wen_r <= 1'b0;
      if (st_r == S_DONE && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_HEAP_BASE) heap_base_r <= cfg_data;
            else free_r <= cfg_data[24:0];
          end else if (in_tvalid && in_tready) begin
            op_r <= in_tuser;
            rnd_r <= rnd_w[31:0];
            need_r <= rnd_w + 33'(HEADER_BYTES);
            addr_r <= in_tdata[63:32];
            off_r <= heap_base_r;
            i_r <= '0;
            wk_addr_r <= '0;
            wk_status_r <= ST_OK;
            ph_r <= '0;
            if (in_tuser == OP_ALLOC) begin
              if (in_tdata[31:0] == '0) begin
                wk_status_r <= ST_ZERO; st_r <= S_DONE;
              end else if (rnd_w[32] || cnt_r >= CW'(MAX_BLOCKS)) begin
                wk_status_r <= ST_NOFIT; st_r <= S_DONE;
              end else st_r <= S_SCAN;
            end else if (in_tdata[63:32] == '0) begin
              wk_status_r <= ST_NULL; st_r <= S_DONE;
            end else st_r <= S_SCAN;
          end
        end
        S_SCAN: st_r <= S_SCHK;  // read of entry i in flight
        S_SCHK: begin
          cur_size_r <= rd_size;
          cur_free_r <= rd_free;
          if (ph_r == 2'd0) ph_r <= 2'd1;
          else begin
            ph_r <= 2'd0;
            if (op_r == OP_ALLOC) begin
              if (cur_free_r && 33'(cur_size_r) >= need_r) begin
                j_r <= cnt_r;
                st_r <= S_SHUP;
              end else if (i_r + 1'b1 >= cnt_r) begin
                wk_status_r <= ST_NOFIT; st_r <= S_DONE;
              end else begin
                off_r <= off_r + blk_bytes; i_r <= i_r + 1'b1; st_r <= S_SCAN;
              end
            end else begin
              if (off_r + 32'(HEADER_BYTES) == addr_r) begin
                if (cur_free_r) begin
                  wk_status_r <= ST_DOUBLE; st_r <= S_DONE;
                end else begin
                  used_r <= used_r - 25'(blk_bytes);
                  free_r <= free_r + 25'(blk_bytes);
                  wen_r <= 1'b1; waddr_r <= i_r[AW-1:0];
                  wsize_r <= cur_size_r; wfree_r <= 1'b1;
                  i_r <= '0; st_r <= S_MRGR;
                end
              end else if (i_r + 1'b1 >= cnt_r) begin
                wk_status_r <= ST_UNKNOWN; st_r <= S_DONE;
              end else begin
                off_r <= off_r + blk_bytes; i_r <= i_r + 1'b1; st_r <= S_SCAN;
              end
            end
          end
        end
        S_SHUP: begin
          // move entry j-1 to j while j > i+1
          if (ph_r == 2'd0) begin
            if (j_r > i_r + 1'b1) ph_r <= 2'd1;
            else st_r <= S_SPLT;
          end else if (ph_r == 2'd1) ph_r <= 2'd2;
          else begin
            wen_r <= 1'b1; waddr_r <= AW'(j_r);
            wsize_r <= rd_size; wfree_r <= rd_free;
            j_r <= j_r - 1'b1; ph_r <= 2'd0;
          end
        end
        S_SPLT: begin
          if (ph_r == 2'd0) begin
            wen_r <= 1'b1; waddr_r <= AW'(i_r + 1'b1);
            wsize_r <= cur_size_r - SW'(rnd_r) - SW'(HEADER_BYTES);
            wfree_r <= 1'b1; ph_r <= 2'd1; st_r <= S_SPLT;
          end else begin
            wen_r <= 1'b1; waddr_r <= i_r[AW-1:0];
            wsize_r <= SW'(rnd_r); wfree_r <= 1'b0;
            cnt_r <= cnt_r + 1'b1;
            used_r <= used_r + 25'(rnd_r) + 25'(HEADER_BYTES);
            free_r <= free_r - 25'(rnd_r) - 25'(HEADER_BYTES);
            wk_addr_r <= off_r + 32'(HEADER_BYTES);
            st_r <= S_DONE;
          end
        end
        S_MRGR: begin
          // set up compare of entries i and i+1
          if (i_r + 1'b1 >= cnt_r) st_r <= S_DONE;
          else begin
            j_r <= i_r; ph_r <= 2'd0; st_r <= S_MRGC;
          end
        end
        S_MRGC: begin
          unique case (ph_r)
            2'd0: ph_r <= 2'd1;
            2'd1: begin
              cur_size_r <= rd_size; cur_free_r <= rd_free;
              j_r <= i_r + 1'b1; ph_r <= 2'd2;
            end
            2'd2: ph_r <= 2'd3;
            default: begin
              if (cur_free_r && rd_free) begin
                wen_r <= 1'b1; waddr_r <= i_r[AW-1:0];
                wsize_r <= cur_size_r + rd_size + SW'(HEADER_BYTES);
                wfree_r <= 1'b1;
                j_r <= i_r + 2'd2; ph_r <= 2'd0; st_r <= S_SHDN;
              end else begin
                i_r <= i_r + 1'b1; st_r <= S_MRGR;
              end
            end
          endcase
        end
        S_SHDN: begin
          // move entry j to j-1 for j < cnt
          if (ph_r == 2'd0) begin
            if (j_r < cnt_r) ph_r <= 2'd1;
            else begin
              cnt_r <= cnt_r - 1'b1; st_r <= S_MRGR;
            end
          end else if (ph_r == 2'd1) ph_r <= 2'd2;
          else begin
            wen_r <= 1'b1; waddr_r <= AW'(j_r - 1'b1);
            wsize_r <= rd_size; wfree_r <= rd_free;
            j_r <= j_r + 1'b1; ph_r <= 2'd0;
          end
        end
        S_DONE: begin
          // hold here while the previous result is still offered
          if (!out_valid_r || out_tready) begin
            res_r.status <= wk_status_r;
            res_r.granted_address <= wk_addr_r;
            res_r.used_bytes <= used_r;
            res_r.free_bytes <= free_r;
            res_r.block_count <= 7'(cnt_r);
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> out_valid_r)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && cnt_r <= CW'(MAX_BLOCKS))
    else $error("block count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(res_r)))
    else $error("waiting result changed");
endmodule

@@ sv/ffha_table.sv @@
module ffha_table #(
  parameter int MAX_BLOCKS = ffha_pkg::MaxBlocksDef,
  parameter int HEAP_BYTES = ffha_pkg::HeapBytesDef,
  parameter int HEADER_BYTES = ffha_pkg::HeaderBytesDef,
  localparam int AW = $clog2(MAX_BLOCKS),
  localparam int SW = $clog2(HEAP_BYTES)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [AW-1:0] rd_addr,
  output logic [SW-1:0] rd_size,
  output logic rd_free,
  input  logic wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [SW-1:0] wr_size,
  input  logic wr_free
);
  import ffha_pkg::*;
  logic [SW-1:0] size_mem [MAX_BLOCKS];
  logic free_mem [MAX_BLOCKS];
  logic [SW-1:0] rd_size_r;
  logic rd_free_r;
  logic e0_wr_r;
  logic rd_zero_r;

  // entry 0 reads as the reset block until first written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      size_mem[wr_addr] <= wr_size;
      free_mem[wr_addr] <= wr_free;
    end
    rd_size_r <= size_mem[rd_addr];
    rd_free_r <= free_mem[rd_addr];
    rd_zero_r <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_wr_r <= 1'b0;
    end else if (wr_en && wr_addr == '0) begin
      e0_wr_r <= 1'b1;
    end
  end

  assign rd_size = (rd_zero_r && !e0_wr_r) ? SW'(HEAP_BYTES - HEADER_BYTES) : rd_size_r;
  assign rd_free = (rd_zero_r && !e0_wr_r) ? 1'b1 : rd_free_r;
endmodule

@@ dv/first_fit_heap_allocator_checker.sv @@
`timescale 1ns / 100ps
module first_fit_heap_allocator_checker #(
  parameter int MAX_BLOCKS = ffha_pkg::MaxBlocksDef,
  parameter int HEADER_BYTES = ffha_pkg::HeaderBytesDef,
  parameter int HEAP_BYTES = ffha_pkg::HeapBytesDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tready,
  input  logic [63:0] in_tdata,
  input  logic in_tuser,
  input  logic out_tvalid,
  input  logic out_tready,
  input  logic [95:0] out_tdata,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  output int err_count,
  output int awaited_count,
  output int result_count
);
  import ffha_pkg::*;

  logic [31:0] heap_base;
  logic [24:0] total_bytes;
  logic [31:0] blk_size [MAX_BLOCKS];
  logic        blk_free [MAX_BLOCKS];
  int          blk_cnt;
  logic [24:0] used_ctr;
  logic [24:0] free_ctr;

  result_t awaited_results[$];

  task automatic shift_out(input int k);
    for (int j = k; j + 1 < blk_cnt; j++) begin
      blk_size[j] = blk_size[j + 1];
      blk_free[j] = blk_free[j + 1];
    end
    blk_cnt--;
  endtask

  task automatic do_allocate(input logic [31:0] req, output logic [2:0] st,
                             output logic [31:0] addr);
    longint rnd;
    logic [31:0] off;
    logic [31:0] r;
    bit done;
    addr = '0;
    st = ST_NOFIT;
    done = 0;
    rnd = (longint'(req) + 7) & ~longint'(7);
    off = heap_base;
    if (req == 0) begin
      st = ST_ZERO;
    end else if (rnd > 64'hFFFF_FFFF || blk_cnt >= MAX_BLOCKS) begin
      st = ST_NOFIT;
    end else begin
      for (int i = 0; i < blk_cnt; i++) begin
        if (!done) begin
          if (blk_free[i] && longint'(blk_size[i]) >= rnd + HEADER_BYTES) begin
            r = rnd[31:0];
            for (int j = blk_cnt; j > i + 1; j--) begin
              blk_size[j] = blk_size[j - 1];
              blk_free[j] = blk_free[j - 1];
            end
            blk_size[i + 1] = blk_size[i] - r - HEADER_BYTES;
            blk_free[i + 1] = 1'b1;
            blk_size[i] = r;
            blk_free[i] = 1'b0;
            blk_cnt++;
            used_ctr = 25'(used_ctr + r + HEADER_BYTES);
            free_ctr = 25'(free_ctr - r - HEADER_BYTES);
            addr = off + HEADER_BYTES;
            st = ST_OK;
            done = 1;
          end else begin
            off = off + blk_size[i] + HEADER_BYTES;
          end
        end
      end
    end
  endtask

  task automatic do_release(input logic [31:0] addr, output logic [2:0] st);
    logic [31:0] off;
    int hit;
    int i;
    hit = -1;
    off = heap_base;
    if (addr == 0) begin
      st = ST_NULL;
    end else begin
      for (int k = 0; k < blk_cnt; k++) begin
        if (hit < 0) begin
          if (32'(off + HEADER_BYTES) == addr) hit = k;
          else off = off + blk_size[k] + HEADER_BYTES;
        end
      end
      if (hit < 0) begin
        st = ST_UNKNOWN;
      end else if (blk_free[hit]) begin
        st = ST_DOUBLE;
      end else begin
        blk_free[hit] = 1'b1;
        used_ctr = 25'(used_ctr - blk_size[hit] - HEADER_BYTES);
        free_ctr = 25'(free_ctr + blk_size[hit] + HEADER_BYTES);
        i = 0;
        while (i + 1 < blk_cnt) begin
          if (blk_free[i] && blk_free[i + 1]) begin
            blk_size[i] = blk_size[i] + blk_size[i + 1] + HEADER_BYTES;
            shift_out(i + 1);
          end else begin
            i++;
          end
        end
        st = ST_OK;
      end
    end
  endtask

  always @(posedge clk) begin
    result_t got, want;
    logic [2:0] st;
    logic [31:0] ga;
    if (!rst_n) begin
      heap_base = HeapBaseRst;
      total_bytes = TotalBytesRst;
      blk_size[0] = HEAP_BYTES - HEADER_BYTES;
      blk_free[0] = 1'b1;
      blk_cnt = 1;
      used_ctr = '0;
      free_ctr = TotalBytesRst;
      awaited_results.delete();
      err_count = 0;
      result_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[2:0];
        got.granted_address = out_tdata[34:3];
        got.used_bytes = out_tdata[59:35];
        got.free_bytes = out_tdata[84:60];
        got.block_count = out_tdata[91:85];
        result_count++;
        if (awaited_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            err_count++;
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          end
          if (got.granted_address !== want.granted_address) begin
            err_count++;
            $display("%0t: granted_address exp %h got %h", $time,
                     want.granted_address, got.granted_address);
          end
          if (got.used_bytes !== want.used_bytes) begin
            err_count++;
            $display("%0t: used_bytes exp %h got %h", $time, want.used_bytes,
                     got.used_bytes);
          end
          if (got.free_bytes !== want.free_bytes) begin
            err_count++;
            $display("%0t: free_bytes exp %h got %h", $time, want.free_bytes,
                     got.free_bytes);
          end
          if (got.block_count !== want.block_count) begin
            err_count++;
            $display("%0t: block_count exp %0d got %0d", $time, want.block_count,
                     got.block_count);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          heap_base = cfg_data;
        end else begin
          total_bytes = cfg_data[24:0];
          free_ctr = cfg_data[24:0];
        end
      end
      if (in_tvalid && in_tready) begin
        ga = '0;
        if (in_tuser == OP_ALLOC) do_allocate(in_tdata[31:0], st, ga);
        else do_release(in_tdata[63:32], st);
        want.status = st;
        want.granted_address = ga;
        want.used_bytes = used_ctr;
        want.free_bytes = free_ctr;
        want.block_count = 7'(blk_cnt);
        awaited_results.push_back(want);
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

@@ dv/tb_first_fit_heap_allocator_top.sv @@
`timescale 1ns / 100ps
module tb_first_fit_heap_allocator_top;
  import ffha_pkg::*;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [63:0] in_tdata;   // [31:0] request_bytes, [63:32] release_address
  logic in_tuser;          // opcode
  logic out_tvalid;
  logic out_tready;
  logic [95:0] out_tdata;  // status, granted_address, used_bytes, free_bytes, block_count
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [31:0] cfg_data;

  int err_count;
  int awaited_count;
  int result_count;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int hold_left;
  int alloc_items;
  int release_items;

  logic [31:0] live_addrs[$];
  logic [31:0] freed_addrs[$];

  first_fit_heap_allocator_top uut (.*);

  first_fit_heap_allocator_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .err_count, .awaited_count, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // granted payloads become candidates for release
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tdata[2:0] == ST_OK &&
        out_tdata[34:3] != 0)
      live_addrs.push_back(out_tdata[34:3]);
  end

  task automatic send_item(input logic op, input logic [31:0] req,
                           input logic [31:0] rel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {rel, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_ALLOC) alloc_items++;
    else release_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic release_live(input bit make_double);
    int k;
    logic [31:0] a;
    if (make_double && freed_addrs.size() > 0) begin
      a = freed_addrs[$urandom_range(freed_addrs.size() - 1)];
    end else if (live_addrs.size() > 0) begin
      k = $urandom_range(live_addrs.size() - 1);
      a = live_addrs[k];
      live_addrs.delete(k);
      freed_addrs.push_back(a);
      if (freed_addrs.size() > 32) void'(freed_addrs.pop_front());
    end else begin
      a = $urandom;
    end
    send_item(OP_FREE, $urandom, a);
  endtask

  function automatic logic [31:0] pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 2) return 0;
    if (p < 5) return $urandom;
    if (p < 12) return $urandom_range(1 << 20, 1);
    return $urandom_range(2048, 1);
  endfunction

  task automatic random_phase(input int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (i == n / 2 && n >= 100) hold_request = 1;
      if (p < 55) begin
        send_item(OP_ALLOC, pick_size(), $urandom);
      end else if (p < 87) begin
        release_live(0);
      end else if (p < 93) begin
        release_live(1);
      end else if (p < 96) begin
        send_item(OP_FREE, $urandom, 32'h0);
      end else begin
        send_item(OP_FREE, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ALLOC;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HEAP_BASE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    alloc_items = 0;
    release_items = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and every status
    send_item(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_ALLOC, 32'hFFFF_FFF9, 32'h0);
    send_item(OP_ALLOC, 32'h1, 32'h0);
    send_item(OP_ALLOC, 32'h8, 32'h0);
    send_item(OP_ALLOC, 32'h9, 32'h0);
    send_item(OP_ALLOC, 32'h0040_0000, 32'h0);
    send_item(OP_FREE, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_FREE, 32'h0, 32'h1234_5679);
    drain();
    release_live(0);
    drain();
    release_live(1);
    release_live(0);
    release_live(0);
    drain();
    // table full: dozens of tiny blocks, then the big tail
    for (int i = 0; i < 66; i++) send_item(OP_ALLOC, $urandom_range(24, 1), 0);
    send_item(OP_ALLOC, 32'h0030_0000, 0);
    drain();
    while (live_addrs.size() > 0) release_live(0);
    drain();

    // random phases with register changes in between
    recv_stall_pct = 0;
    send_idle_pct = 0;
    random_phase(165);
    drain();
    write_reg(CFG_HEAP_BASE, 32'h0);
    write_reg(CFG_TOTAL, 32'h0);
    live_addrs.delete();
    freed_addrs.delete();
    send_idle_pct = 54;
    random_phase(165);
    drain();
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF0);
    write_reg(CFG_TOTAL, 32'h0100_0000);
    live_addrs.delete();
    freed_addrs.delete();
    send_idle_pct = 0;
    recv_stall_pct = 54;
    random_phase(165);
    drain();
    write_reg(CFG_HEAP_BASE, $urandom);
    write_reg(CFG_TOTAL, $urandom_range(32'h0100_0000));
    live_addrs.delete();
    freed_addrs.delete();
    send_idle_pct = 9;
    recv_stall_pct = 9;
    random_phase(165);
    drain();

    $display("run covered %0d allocate and %0d free items, %0d results checked",
             alloc_items, release_items, result_count);
    $display("register settings: reset values, base 0, base near wrap, random");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
